// ===== design/stuffed_reply_deframer_defines.svh =====
// assertion macros shared by the stuffed reply deframer checkers
// no dependencies; expects clk and rst_n in the including scope
`ifndef STUFFED_REPLY_DEFRAMER_DEFINES_SVH
`define STUFFED_REPLY_DEFRAMER_DEFINES_SVH

// checked only while out of reset
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/srd_pkg.sv =====
// shared types and constants of the stuffed reply deframer
// no dependencies
`timescale 1ns / 1ps

package srd_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 9;
  localparam int DEF_MAX_PAYLOAD = 256;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hDB;
  localparam logic [BYTE_W-1:0] ESC_LF     = 8'hDC;
  localparam logic [BYTE_W-1:0] ESC_ESC    = 8'hDD;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;
  localparam logic [BYTE_W-1:0] TYPE_OK    = 8'h6F;  // 'o'
  localparam logic [BYTE_W-1:0] TYPE_ERR   = 8'h65;  // 'e'

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DEV_ERR  = 3'd1,
    ST_CSUM_BAD = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_BAD_TYPE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_DATA,
    PH_CODE,
    PH_CSUM,
    PH_TERM
  } phase_t;

  typedef struct packed {
    logic              frame_end;
    logic [BYTE_W-1:0] data_byte;
    status_t           status;
    logic [BYTE_W-1:0] device_code;
  } srd_res_t;

endpackage

// ===== design/stuffed_reply_deframer.sv =====
// top level of the stuffed reply deframer: input stage, frame logic, result stage
// depends on srd_pkg, srd_in_stage, srd_frame_fsm, srd_out_stage
//
//   channel  | ports                         | payload
//   ---------+-------------------------------+----------------------------------
//   input    | in_tvalid in_tready in_tdata  | wire_byte
//   result   | out_tvalid out_tready         | tlast = frame_end, tdata = data,
//            | out_tdata out_tlast           | status, device_code
//   config   | cfg_valid cfg_ready cfg_data  | payload_length, always ready
//
// one item per cycle while the result side is not stalled; an accepted item passes the
// input register, then the result register after one pass of frame logic
// rst_n is synchronous; it clears both stages, the frame state and payload_length to 256
// a stalled result holds the result register, the input register fills and then
// in_tready drops; an item that gives no result frees the pipe without a result
`timescale 1ns / 1ps

module stuffed_reply_deframer #(
  parameter int MAX_PAYLOAD = srd_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [srd_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] wire_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] data_byte, [10:8] status, [18:11] device_code, [23:19] zero
  output logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srd_pkg::LEN_W-1:0]       cfg_data
);
  import srd_pkg::*;

  logic              adv;
  logic              fire;
  logic [BYTE_W-1:0] byte_q;
  logic              res_vld;
  srd_res_t          res;
  logic [LEN_W-1:0]  len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      len_r <= cfg_data;
    end
  end

  srd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .fire      (fire),
    .byte_q    (byte_q)
  );

  srd_frame_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .byte_in        (byte_q),
    .payload_length (len_r),
    .res_vld        (res_vld),
    .res            (res)
  );

  srd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_vld),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/srd_in_stage.sv =====
// input register stage: holds one received wire byte until the frame logic takes it
// depends on srd_pkg
`timescale 1ns / 1ps

module srd_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [srd_pkg::BYTE_W-1:0] in_tdata,
  input  logic                      adv,
  output logic                      fire,
  output logic [srd_pkg::BYTE_W-1:0] byte_q
);
  import srd_pkg::*;

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  assign fire      = valid_r & adv;
  assign in_tready = ~valid_r | adv;
  assign byte_q    = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

endmodule

// ===== design/srd_frame_fsm.sv =====
// unescaping, checksum and frame phase tracking for one wire byte per cycle while fire is high
// depends on srd_pkg
`timescale 1ns / 1ps

module srd_frame_fsm #(
  parameter int MAX_PAYLOAD = srd_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [srd_pkg::BYTE_W-1:0] byte_in,
  input  logic [srd_pkg::LEN_W-1:0] payload_length,
  output logic                      res_vld,
  output srd_pkg::srd_res_t         res
);
  import srd_pkg::*;

  localparam int LenCap = (MAX_PAYLOAD > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : MAX_PAYLOAD;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCap);

  phase_t            phase_r, phase_nxt;
  logic              esc_r, esc_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  seen_r, seen_nxt;
  logic              is_err_r, is_err_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;

  logic              esc_dec;
  logic              bad_esc;
  logic              have_d;
  logic [BYTE_W-1:0] dec;
  logic [BYTE_W-1:0] sum_new;
  logic [LEN_W-1:0]  seen_inc;
  logic [LEN_W-1:0]  eff_len;
  logic              finish;
  status_t           fin_status;
  status_t           end_status;

  // byte unstuffing and running sum; terminator bytes stay out of the sum
  always_comb begin
    sum_new = (phase_r != PH_TERM) ? sum_r + byte_in : sum_r;
    esc_dec = 1'b0;
    bad_esc = 1'b0;
    have_d  = 1'b0;
    dec     = byte_in;
    if (esc_r) begin
      if (byte_in == ESC_LF) begin
        dec    = LF_BYTE;
        have_d = 1'b1;
      end else if (byte_in == ESC_ESC) begin
        dec    = ESC_BYTE;
        have_d = 1'b1;
      end else begin
        bad_esc = 1'b1;
      end
    end else if (byte_in == ESC_BYTE) begin
      esc_dec = 1'b1;
    end else begin
      have_d = 1'b1;
    end
  end

  always_comb begin
    if (payload_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (payload_length > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = payload_length;
    end
    seen_inc = seen_r + LEN_W'(1);
  end

  always_comb begin
    if (sum_new != '0) begin
      end_status = ST_CSUM_BAD;
    end else if (is_err_r) begin
      end_status = ST_DEV_ERR;
    end else begin
      end_status = ST_OK;
    end
    finish     = 1'b0;
    fin_status = end_status;
    if (bad_esc) begin
      finish     = 1'b1;
      fin_status = ST_BAD_ESC;
    end else if (have_d) begin
      unique case (phase_r)
        PH_TYPE: begin
          if (dec != TYPE_OK && dec != TYPE_ERR) begin
            finish     = 1'b1;
            fin_status = ST_BAD_TYPE;
          end
        end
        PH_CSUM: finish = (dec == LF_BYTE);
        PH_TERM: finish = 1'b1;
        default: finish = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    sum_nxt    = sum_r;
    seen_nxt   = seen_r;
    is_err_nxt = is_err_r;
    code_nxt   = code_r;
    if (fire) begin
      esc_nxt = esc_dec;
      sum_nxt = sum_new;
      if (finish) begin
        phase_nxt  = PH_TYPE;
        esc_nxt    = 1'b0;
        sum_nxt    = '0;
        seen_nxt   = '0;
        is_err_nxt = 1'b0;
        code_nxt   = '0;
      end else if (have_d) begin
        unique case (phase_r)
          PH_TYPE: begin
            if (dec == TYPE_OK) begin
              is_err_nxt = 1'b0;
              seen_nxt   = '0;
              phase_nxt  = PH_DATA;
            end else begin
              is_err_nxt = 1'b1;
              phase_nxt  = PH_CODE;
            end
          end
          PH_DATA: begin
            seen_nxt = seen_inc;
            if (seen_inc >= eff_len) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CODE: begin
            code_nxt  = dec;
            phase_nxt = PH_CSUM;
          end
          PH_CSUM: phase_nxt = PH_TERM;
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_vld         = fire & (finish | (have_d & (phase_r == PH_DATA)));
    res.frame_end   = finish;
    res.data_byte   = finish ? '0 : dec;
    res.status      = finish ? fin_status : ST_OK;
    res.device_code = (finish && is_err_r) ? code_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      esc_r    <= 1'b0;
      sum_r    <= '0;
      seen_r   <= '0;
      is_err_r <= 1'b0;
      code_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      sum_r    <= sum_nxt;
      seen_r   <= seen_nxt;
      is_err_r <= is_err_nxt;
      code_r   <= code_nxt;
    end
  end

endmodule

// ===== design/srd_out_stage.sv =====
// result register: holds one result item until the sink takes it
// depends on srd_pkg
`timescale 1ns / 1ps

module srd_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  srd_pkg::srd_res_t              res,
  output logic                           adv,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import srd_pkg::*;

  logic     valid_r;
  srd_res_t res_r;

  assign adv        = ~valid_r | out_tready;
  assign out_tvalid = valid_r;
  assign out_tlast  = res_r.frame_end;
  assign out_tdata  = {5'b0, res_r.device_code, res_r.status, res_r.data_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res;
    end
  end

endmodule

// ===== design/srd_checker.sv =====
// port-level checks of the stuffed reply deframer, bound to the top level
// depends on srd_pkg and stuffed_reply_deframer_defines.svh
`timescale 1ns / 1ps
`include "stuffed_reply_deframer_defines.svh"

module srd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import srd_pkg::*;

  `SRD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")
  `SRD_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_tvalid, "result valid right after reset")
  `SRD_ASSERT(a_in_stall, !in_tready |-> out_tvalid && !out_tready, "input stalled without output stall")
  `SRD_ASSERT(a_data_clean, out_tvalid && !out_tlast |-> out_tdata[18:8] == 11'd0, "data item carries status or code")
  `SRD_ASSERT(a_code_status, out_tvalid && out_tlast && out_tdata[18:11] != 8'd0 |-> out_tdata[10:8] != ST_OK && out_tdata[10:8] != ST_BAD_TYPE, "device code with wrong status")

endmodule

bind stuffed_reply_deframer srd_checker u_srd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/tb_stuffed_reply_deframer.sv =====
// self-checking testbench for stuffed_reply_deframer: byte-stuffed reply frames in,
// decoded payload bytes and frame status out, checked against an in-bench frame decoder
// depends on srd_pkg and the stuffed_reply_deframer rtl
`timescale 1ns / 1ps

module tb_stuffed_reply_deframer;
  import srd_pkg::*;

  localparam int ITEMS = 1700;
  localparam logic [BYTE_W-1:0] LF_PAIR_SUM  = ESC_BYTE + ESC_LF;   // wire sum of db dc
  localparam logic [BYTE_W-1:0] ESC_PAIR_SUM = ESC_BYTE + ESC_ESC;  // wire sum of db dd

  typedef enum int {RX_OPEN, RX_THREE_OF_FOUR, RX_COIN, RX_BURSTY} rx_mode_t;

  // decodes the wire stream the same way the block should and queues the results
  class reply_scoreboard;
    phase_t            phase;
    bit                esc_pending;
    logic [BYTE_W-1:0] wire_sum;
    logic [LEN_W-1:0]  bytes_seen;
    bit                is_err;
    logic [BYTE_W-1:0] held_code;
    logic [LEN_W-1:0]  length_reg;
    srd_res_t          pending[$];
    int                mismatches;

    function new();
      length_reg = LEN_W'(DEF_MAX_PAYLOAD);
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase       = PH_TYPE;
      esc_pending = 0;
      wire_sum    = '0;
      bytes_seen  = '0;
      is_err      = 0;
      held_code   = '0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      length_reg = v;
    endfunction

    function int unsigned frame_length();
      if (length_reg == 0) return 1;
      if (length_reg > DEF_MAX_PAYLOAD) return DEF_MAX_PAYLOAD;
      return length_reg;
    endfunction

    function status_t end_status();
      if (wire_sum != 0) return ST_CSUM_BAD;
      return is_err ? ST_DEV_ERR : ST_OK;
    endfunction

    function void close_frame(status_t st);
      srd_res_t r;
      r.frame_end   = 1'b1;
      r.data_byte   = '0;
      r.status      = st;
      r.device_code = is_err ? held_code : '0;
      pending.push_back(r);
      clear_frame();
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] d;
      srd_res_t          r;
      // terminator bytes stay out of the checksum
      if (phase != PH_TERM) wire_sum += b;
      if (esc_pending) begin
        esc_pending = 0;
        if (b == ESC_LF) d = LF_BYTE;
        else if (b == ESC_ESC) d = ESC_BYTE;
        else begin
          close_frame(ST_BAD_ESC);
          return;
        end
      end else if (b == ESC_BYTE) begin
        esc_pending = 1;
        return;
      end else begin
        d = b;
      end
      case (phase)
        PH_TYPE: begin
          if (d == TYPE_OK) begin
            is_err     = 0;
            bytes_seen = '0;
            phase      = PH_DATA;
          end else if (d == TYPE_ERR) begin
            is_err = 1;
            phase  = PH_CODE;
          end else begin
            close_frame(ST_BAD_TYPE);
          end
        end
        PH_DATA: begin
          r.frame_end   = 1'b0;
          r.data_byte   = d;
          r.status      = ST_OK;
          r.device_code = '0;
          pending.push_back(r);
          bytes_seen = bytes_seen + 1'b1;
          if (bytes_seen >= frame_length()) phase = PH_CSUM;
        end
        PH_CODE: begin
          held_code = d;
          phase     = PH_CSUM;
        end
        PH_CSUM: begin
          if (d == LF_BYTE) close_frame(end_status());
          else phase = PH_TERM;
        end
        default: close_frame(end_status());
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic last, logic [OUT_TDATA_W-1:0] d);
      srd_res_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: end %0b data %02h status %0d code %02h pad %02h",
                       last, d[7:0], d[10:8], d[18:11], d[23:19]));
        return;
      end
      want = pending.pop_front();
      if (last !== want.frame_end || d[7:0] !== want.data_byte ||
          d[10:8] !== want.status || d[18:11] !== want.device_code || d[23:19] !== '0)
        flag($sformatf({"result mismatch (exp/got): end %0b/%0b data %02h/%02h ",
                        "status %0d/%0d code %02h/%02h pad 00/%02h"},
                       want.frame_end, last, want.data_byte, d[7:0],
                       want.status, d[10:8], want.device_code, d[18:11], d[23:19]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data = '0;

  reply_scoreboard   sb;
  logic [BYTE_W-1:0] frame_q[$];
  int                cur_len = DEF_MAX_PAYLOAD;
  int                items_sent = 0;
  int                burst_left = 0;
  rx_mode_t          rx_mode = RX_OPEN;
  int                rx_tick = 0;
  int                stall_left = 0;

  stuffed_reply_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: ready pattern picks a new random mode whenever rx_tick is a multiple of 97
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:          out_tready <= 1'b1;
        RX_THREE_OF_FOUR: out_tready <= (rx_tick % 4) != 3;
        RX_COIN:          out_tready <= $urandom_range(0, 2) != 0;
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 25);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tlast, out_tdata);
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return LF_BYTE;
      1:       return ESC_BYTE;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // stuff one decoded byte; a line feed goes out raw or escaped
  function automatic void add_coded(logic [BYTE_W-1:0] d);
    if (d == ESC_BYTE) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_ESC);
    end else if (d == LF_BYTE && $urandom_range(0, 1)) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_LF);
    end else begin
      frame_q.push_back(d);
    end
  endfunction

  // fill < 0 means random body bytes; the checksum zeroes the wire sum unless bad_sum
  function automatic void build_frame(logic [BYTE_W-1:0] typ, int n_data, int fill,
                                      bit bad_sum);
    logic [BYTE_W-1:0] target, csd, r;
    do begin
      frame_q.delete();
      frame_q.push_back(typ);
      if (typ == TYPE_ERR) n_data = 1;
      for (int i = 0; i < n_data; i++) add_coded(fill >= 0 ? 8'(fill) : pick_byte());
      target = '0;
      foreach (frame_q[i]) target -= frame_q[i];
    end while (!bad_sum && target == ESC_BYTE);
    if (bad_sum) begin
      do r = 8'($urandom_range(0, 255)); while (r == target || r == ESC_BYTE);
      frame_q.push_back(r);
      csd = r;
    end else if (target == LF_PAIR_SUM && $urandom_range(0, 1)) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_LF);
      csd = LF_BYTE;
    end else if (target == ESC_PAIR_SUM && $urandom_range(0, 1)) begin
      frame_q.push_back(ESC_BYTE);
      frame_q.push_back(ESC_ESC);
      csd = ESC_BYTE;
    end else begin
      frame_q.push_back(target);
      csd = target;
    end
    // terminator only when the checksum did not decode to a line feed
    if (csd != LF_BYTE) begin
      case ($urandom_range(0, 5))
        0: begin
          frame_q.push_back(ESC_BYTE);
          frame_q.push_back(ESC_LF);
        end
        1: begin
          frame_q.push_back(ESC_BYTE);
          frame_q.push_back(ESC_ESC);
        end
        2: begin
          do r = 8'($urandom_range(0, 255)); while (r == ESC_BYTE);
          frame_q.push_back(r);
        end
        default: frame_q.push_back(LF_BYTE);
      endcase
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  // stop sending until every pending result is out and the pipe has emptied
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(v);
    cur_len = (v == 0) ? 1 : (v > DEF_MAX_PAYLOAD) ? DEF_MAX_PAYLOAD : v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                sel, idx, p, rand_start;
    logic [BYTE_W-1:0] typ, f;
    logic [LEN_W-1:0]  v;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: length 0 acts as one data byte
    write_length('0);
    build_frame(TYPE_OK, 1, 8'hFF, 1'b0);
    send_frame();
    build_frame(TYPE_OK, 1, ESC_BYTE, 1'b0);
    send_frame();
    build_frame(TYPE_ERR, 1, 8'h00, 1'b0);
    send_frame();
    // bad checksum beats device error
    build_frame(TYPE_ERR, 1, LF_BYTE, 1'b1);
    send_frame();
    // plain and escaped bad type, then a bad escape in the checksum byte
    frame_q = '{8'h00, ESC_BYTE, ESC_LF, TYPE_OK, 8'h00, ESC_BYTE, 8'h00};
    send_frame();

    p = 0;
    rand_start = items_sent;
    while (items_sent - rand_start < ITEMS) begin
      case (p)
        0: v = LEN_W'(1);
        1: v = LEN_W'(DEF_MAX_PAYLOAD);
        2: v = '1;
        3: v = LEN_W'(2);
        default: begin
          if ($urandom_range(0, 15) == 0) v = LEN_W'($urandom_range(DEF_MAX_PAYLOAD - 8, 511));
          else v = LEN_W'($urandom_range(1, 8));
        end
      endcase
      write_length(v);
      repeat (cur_len > 32 ? 2 : $urandom_range(4, 16)) begin
        sel = $urandom_range(0, 99);
        typ = ($urandom_range(0, 2) == 0) ? TYPE_ERR : TYPE_OK;
        if (sel < 55) begin
          build_frame(TYPE_OK, cur_len, -1, 1'b0);
        end else if (sel < 70) begin
          build_frame(TYPE_ERR, 1, -1, 1'b0);
        end else if (sel < 78) begin
          build_frame(typ, cur_len, -1, 1'b1);
        end else if (sel < 88) begin
          // bad escape dropped anywhere in an otherwise good frame
          build_frame(typ, cur_len, -1, 1'b0);
          idx = $urandom_range(0, frame_q.size() - 1);
          do f = 8'($urandom_range(0, 255)); while (f == ESC_LF || f == ESC_ESC);
          frame_q.insert(idx, f);
          frame_q.insert(idx, ESC_BYTE);
        end else if (sel < 95) begin
          case ($urandom_range(0, 4))
            0: frame_q.push_back(8'h00);
            1: frame_q.push_back(8'hFF);
            2: begin
              do f = 8'($urandom_range(0, 255));
              while (f == TYPE_OK || f == TYPE_ERR || f == ESC_BYTE);
              frame_q.push_back(f);
            end
            3: frame_q = '{ESC_BYTE, ESC_LF};
            default: frame_q = '{ESC_BYTE, ESC_ESC};
          endcase
        end else begin
          repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
      end
      p++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    sb.mismatches += sb.pending.size();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
